// ----- hw/rtl/b64lw_pkg.sv -----
package b64lw_pkg;

  // Default sizes
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0]  LINE_LENGTH_RST = 8'd76;
  localparam logic [7:0]  MIN_LINE        = 8'd4;

  // Character codes
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] CR_CHAR  = 8'h0D;
  localparam logic [7:0] LF_CHAR  = 8'h0A;

  // Register byte offsets
  localparam logic [2:0] REG_LINE_LENGTH = 3'd0;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } out_item_t;

  // One classified input byte: up to four characters, no line breaks yet
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;   // index of the final character in chars
    logic            last;       // closes the message
  } grp_t;

  // Map a 6-bit value to its base64 symbol
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b64lw_front.sv -----
module b64lw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  b64lw_pkg::in_item_t in_item,
  output b64lw_pkg::grp_t    grp
);
  import b64lw_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] b;

  assign b = in_item.data_byte;

  // Classify the byte into its group characters and next phase
  always_comb begin
    grp       = '0;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    grp.last  = in_item.last_byte;
    unique case (phase_r)
      2'd1: begin
        grp.chars[0] = sym({left_r[1:0], b[7:4]});
        if (in_item.last_byte) begin
          grp.chars[1] = sym({b[3:0], 2'b00});
          grp.chars[2] = PAD_CHAR;
          grp.last_idx = 2'd2;
        end else begin
          grp.last_idx = 2'd0;
          left_nxt     = b[3:0];
          phase_nxt    = 2'd2;
        end
      end
      2'd2: begin
        grp.chars[0] = sym({left_r, b[7:6]});
        grp.chars[1] = sym(b[5:0]);
        grp.last_idx = 2'd1;
        left_nxt     = 4'd0;
        phase_nxt    = 2'd0;
      end
      default: begin
        grp.chars[0] = sym(b[7:2]);
        if (in_item.last_byte) begin
          grp.chars[1] = sym({b[1:0], 4'b0000});
          grp.chars[2] = PAD_CHAR;
          grp.chars[3] = PAD_CHAR;
          grp.last_idx = 2'd3;
        end else begin
          grp.last_idx = 2'd0;
          left_nxt     = {2'b00, b[1:0]};
          phase_nxt    = 2'd1;
        end
      end
    endcase
    if (in_item.last_byte) begin
      phase_nxt = 2'd0;
      left_nxt  = 4'd0;
    end
  end

  // Advance group state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64lw_queue.sv -----
module b64lw_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b64lw_pkg::grp_t wr_data,
  input  logic           rd_en,
  output b64lw_pkg::grp_t rd_data,
  output logic           full,
  output logic           empty
);
  import b64lw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  grp_t            mem_r [Depth];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/b64lw_back.sv -----
module b64lw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          line_length,
  input  logic                q_empty,
  input  b64lw_pkg::grp_t     q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output b64lw_pkg::out_item_t out_data
);
  import b64lw_pkg::*;

  typedef enum logic [1:0] {
    BK_CHAR = 2'b01,
    BK_LF   = 2'b10
  } bk_state_t;

  bk_state_t  state_r, state_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [7:0] col_r, col_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;
  logic [7:0] limit;
  logic       slot_free;

  assign limit     = (line_length < MIN_LINE) ? MIN_LINE : line_length;
  assign slot_free = !ov_r || pop;
  assign empty     = !ov_r;
  assign out_data  = od_r;

  // Emit one char per cycle unless stalled; CR LF at the line limit
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    od_nxt    = od_r;
    ov_nxt    = ov_r && !pop;
    q_pop     = 1'b0;
    if (slot_free && !q_empty) begin
      ov_nxt = 1'b1;
      unique case (state_r)
        BK_LF: begin
          od_nxt    = '{out_char: LF_CHAR, end_of_text: 1'b0};
          col_nxt   = 8'd0;
          state_nxt = BK_CHAR;
        end
        BK_CHAR: begin
          if (col_r >= limit) begin
            od_nxt    = '{out_char: CR_CHAR, end_of_text: 1'b0};
            state_nxt = BK_LF;
          end else begin
            od_nxt.out_char    = q_head.chars[pos_r];
            od_nxt.end_of_text = q_head.last && (pos_r == q_head.last_idx);
            col_nxt            = col_r + 8'd1;
            pos_nxt            = pos_r + 2'd1;
            if (pos_r == q_head.last_idx) begin
              q_pop   = 1'b1;
              pos_nxt = 2'd0;
              if (q_head.last) begin
                col_nxt = 8'd0;
              end
            end
          end
        end
        default: begin
          state_nxt = BK_CHAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CHAR;
      pos_r   <= 2'd0;
      col_r   <= 8'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

endmodule

// ----- hw/rtl/base64_encoder_line_wrap_unit.sv -----
// Streaming base64 encoder with CR LF line wrapping.
// Input channel: push one byte with its last-byte flag while full is low.
// Result channel: while empty is low, out_data holds the oldest encoded
// character (symbol, '=', CR or LF); pop takes it. end_of_text marks the
// final character of a message.
// Configuration: APB register line_length at offset 0 (values below 4 act
// as 4); write it only while the block is idle.
// An accepted byte is written into the queue, and its first character is
// then registered in the output register before it shows on out_data.
// Throughput: one character per cycle while the receiver pops and the queue
// holds a group, set by the single output register; a byte yields one or
// two characters mid-message (up to six with padding and a line break).
// Reset clears group phase, leftover bits, line column and the queue, and
// sets line_length to 76.
// A stalled receiver holds the output register; accepted bytes collect in
// the queue between front and back, and full rises once it holds
// QueueDepth transactions.
module base64_encoder_line_wrap_unit #(
  parameter int unsigned QueueDepth = b64lw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  b64lw_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output b64lw_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import b64lw_pkg::*;

  logic       in_fire;
  grp_t       grp;
  grp_t       q_head;
  logic       q_empty;
  logic       q_pop;
  logic [7:0] line_length_r;
  logic       reg_sel;

  assign in_fire = push && !full;
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_LINE_LENGTH[2]);

  // Register write and read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      line_length_r <= pwdata[7:0];
    end
  end

  assign prdata = reg_sel ? {24'd0, line_length_r} : 32'd0;

  b64lw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .grp     (grp)
  );

  b64lw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire),
    .wr_data (grp),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  b64lw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_length (line_length_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data    (out_data)
  );

endmodule
